FILE: rtl/clcd_pkg.sv
// Package for the character LCD controller: word types, register map,
// request and sequence codes, and LCD command bytes. No dependencies.
package clcd_pkg;

  // Longest string that can be loaded for one write request.
  localparam int MaxChars = 16;
  localparam int StoreAw  = $clog2(MaxChars);

  // Kind codes of a command word.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_INIT   = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_CURSOR = 3'd3;
  localparam logic [2:0] KIND_LOAD   = 3'd4;

  // Status codes of a response word.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_BAD_POS  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_TICK_MS       = 3'd0;
  localparam logic [2:0] REG_POWER_ON_WAIT = 3'd1;
  localparam logic [2:0] REG_FUNC_SET_WAIT = 3'd2;
  localparam logic [2:0] REG_DISPLAY_WAIT  = 3'd3;
  localparam logic [2:0] REG_ENTRY_WAIT    = 3'd4;

  // LCD command bytes.
  localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY      = 8'h06;
  localparam logic [7:0] CMD_DDRAM      = 8'h80;
  localparam logic [7:0] LINE2_BASE     = 8'h40;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_INIT,
    MODE_OPER
  } mode_t;

  typedef enum logic [2:0] {
    STEP_POWER,
    STEP_FUNC,
    STEP_DISP,
    STEP_CLEAR,
    STEP_ENTRY,
    STEP_END
  } step_t;

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_CLEAR,
    REQ_CURSOR
  } req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic       last_char;
    logic       row;
    logic [4:0] column;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       accepted;
    logic       busy_res;
    logic       operational;
    logic       done_res;
    logic       lcd_rs;
    logic       lcd_en;
    logic [7:0] lcd_data;
  } rsp_word_t;

  typedef struct packed {
    logic [7:0]  tick_ms;
    logic [15:0] power_on_wait;
    logic [15:0] func_set_wait;
    logic [15:0] display_wait;
    logic [15:0] entry_wait;
  } cfg_regs_t;

endpackage

FILE: rtl/clcd_cfg_regs.sv
// Configuration register file of the character LCD controller.
// Depends on clcd_pkg for the register map and the cfg_regs_t struct.
module clcd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output clcd_pkg::cfg_regs_t regs
);

  // Writes are always taken; an index past the map is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tick_ms       <= 8'd2;
      regs.power_on_wait <= 16'd30;
      regs.func_set_wait <= 16'd20;
      regs.display_wait  <= 16'd20;
      regs.entry_wait    <= 16'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        clcd_pkg::REG_TICK_MS:       regs.tick_ms       <= cfg_data[7:0];
        clcd_pkg::REG_POWER_ON_WAIT: regs.power_on_wait <= cfg_data;
        clcd_pkg::REG_FUNC_SET_WAIT: regs.func_set_wait <= cfg_data;
        clcd_pkg::REG_DISPLAY_WAIT:  regs.display_wait  <= cfg_data;
        clcd_pkg::REG_ENTRY_WAIT:    regs.entry_wait    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/clcd_core.sv
// Controller state and the single-pass update for one command word.
// Depends on clcd_pkg for word types, codes and LCD command bytes.
module clcd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  clcd_pkg::cmd_word_t item,
  input  clcd_pkg::cfg_regs_t cfg,
  output clcd_pkg::rsp_word_t res
);

  clcd_pkg::mode_t mode, mode_next;
  clcd_pkg::step_t init_step, init_step_next;
  clcd_pkg::req_t  request_type, request_type_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic        en_level, en_level_next;
  logic        request_busy, request_busy_next;
  logic [4:0]  string_length, string_length_next;
  logic [4:0]  load_count, load_count_next;
  logic [4:0]  write_index, write_index_next;
  logic        cursor_row, cursor_row_next;
  logic [4:0]  cursor_column, cursor_column_next;
  logic        pin_rs, pin_rs_next;
  logic [7:0]  pin_data, pin_data_next;

  logic [7:0] string_store [clcd_pkg::MaxChars];

  logic [16:0] elapsed_sum;
  logic [15:0] elapsed_sat;
  logic        ready_op;
  logic        store_we;
  logic [7:0]  store_rd;
  logic [4:0]  column_less_full;
  logic [3:0]  column_less;
  logic [7:0]  cursor_cmd;
  logic [1:0]  status;
  logic        accepted;
  logic        done;

  assign elapsed_sum = {1'b0, elapsed_ms} + {9'd0, cfg.tick_ms};
  assign elapsed_sat = elapsed_sum[16] ? clcd_pkg::ELAPSED_MAX : elapsed_sum[15:0];
  assign ready_op    = !request_busy && (mode == clcd_pkg::MODE_OPER);
  assign store_rd    = string_store[write_index[clcd_pkg::StoreAw-1:0]];
  assign column_less_full = cursor_column - 5'd1;
  assign column_less = column_less_full[3:0];
  assign cursor_cmd  = clcd_pkg::CMD_DDRAM
                     | (cursor_row ? clcd_pkg::LINE2_BASE : 8'h00)
                     | {4'd0, column_less};
  assign store_we    = fire && (item.kind == clcd_pkg::KIND_LOAD)
                     && (load_count < 5'(clcd_pkg::MaxChars)) && !request_busy;

  // Next-state logic. A transfer phase flips the enable level and drives register
  // select; the rising phase also drives new data.
  always_comb begin
    mode_next          = mode;
    init_step_next     = init_step;
    request_type_next  = request_type;
    elapsed_ms_next    = elapsed_ms;
    en_level_next      = en_level;
    request_busy_next  = request_busy;
    string_length_next = string_length;
    load_count_next    = load_count;
    write_index_next   = write_index;
    cursor_row_next    = cursor_row;
    cursor_column_next = cursor_column;
    pin_rs_next        = pin_rs;
    pin_data_next      = pin_data;
    status             = clcd_pkg::STATUS_OK;
    accepted           = 1'b0;
    done               = 1'b0;

    case (item.kind)
      clcd_pkg::KIND_TICK: begin
        elapsed_ms_next = elapsed_sat;
        if (mode == clcd_pkg::MODE_INIT) begin
          if (init_step == clcd_pkg::STEP_END) begin
            mode_next         = clcd_pkg::MODE_OPER;
            request_busy_next = 1'b0;
            done              = 1'b1;
          end else if (init_step == clcd_pkg::STEP_POWER) begin
            if (elapsed_sat > cfg.power_on_wait) begin
              init_step_next  = clcd_pkg::STEP_FUNC;
              elapsed_ms_next = 16'd0;
            end
          end else begin
            en_level_next = !en_level;
            pin_rs_next   = 1'b0;
            case (init_step)
              clcd_pkg::STEP_FUNC: begin
                if (!en_level) pin_data_next = clcd_pkg::CMD_FUNC_SET;
                if (en_level && elapsed_sat > cfg.func_set_wait) begin
                  init_step_next  = clcd_pkg::STEP_DISP;
                  elapsed_ms_next = 16'd0;
                end
              end
              clcd_pkg::STEP_DISP: begin
                if (!en_level) pin_data_next = clcd_pkg::CMD_DISPLAY_ON;
                if (en_level && elapsed_sat > cfg.display_wait) begin
                  init_step_next  = clcd_pkg::STEP_CLEAR;
                  elapsed_ms_next = 16'd0;
                end
              end
              clcd_pkg::STEP_CLEAR: begin
                if (!en_level) pin_data_next = clcd_pkg::CMD_CLEAR;
                if (en_level && elapsed_sat > cfg.display_wait) begin
                  init_step_next  = clcd_pkg::STEP_ENTRY;
                  elapsed_ms_next = 16'd0;
                end
              end
              clcd_pkg::STEP_ENTRY: begin
                if (!en_level) pin_data_next = clcd_pkg::CMD_ENTRY;
                if (en_level && elapsed_sat > cfg.entry_wait) begin
                  init_step_next  = clcd_pkg::STEP_END;
                  elapsed_ms_next = 16'd0;
                end
              end
              default: ;
            endcase
          end
        end else if (mode == clcd_pkg::MODE_OPER && request_busy) begin
          case (request_type)
            clcd_pkg::REQ_WRITE: begin
              if (write_index < string_length
                  && write_index < 5'(clcd_pkg::MaxChars)) begin
                en_level_next = !en_level;
                pin_rs_next   = 1'b1;
                if (!en_level) pin_data_next = store_rd;
                else write_index_next = write_index + 5'd1;
              end else begin
                write_index_next  = 5'd0;
                request_busy_next = 1'b0;
                done              = 1'b1;
              end
            end
            clcd_pkg::REQ_CLEAR, clcd_pkg::REQ_CURSOR: begin
              en_level_next = !en_level;
              pin_rs_next   = 1'b0;
              if (!en_level) begin
                pin_data_next = (request_type == clcd_pkg::REQ_CLEAR)
                              ? clcd_pkg::CMD_CLEAR : cursor_cmd;
              end else begin
                request_busy_next = 1'b0;
                done              = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      clcd_pkg::KIND_INIT: begin
        if (!request_busy) begin
          mode_next         = clcd_pkg::MODE_INIT;
          init_step_next    = clcd_pkg::STEP_POWER;
          request_busy_next = 1'b1;
          accepted          = 1'b1;
        end
      end
      clcd_pkg::KIND_CLEAR: begin
        if (ready_op) begin
          request_busy_next = 1'b1;
          request_type_next = clcd_pkg::REQ_CLEAR;
          accepted          = 1'b1;
        end
      end
      clcd_pkg::KIND_CURSOR: begin
        if (item.column == 5'd0 || item.column > 5'(clcd_pkg::MaxChars)) begin
          status = clcd_pkg::STATUS_BAD_POS;
        end else if (ready_op) begin
          cursor_row_next    = item.row;
          cursor_column_next = item.column;
          request_busy_next  = 1'b1;
          request_type_next  = clcd_pkg::REQ_CURSOR;
          accepted           = 1'b1;
        end
      end
      clcd_pkg::KIND_LOAD: begin
        // The count stops one past the limit so an overlong string is seen.
        if (load_count <= 5'(clcd_pkg::MaxChars)) load_count_next = load_count + 5'd1;
        if (item.last_char) begin
          if (load_count_next > 5'(clcd_pkg::MaxChars)) begin
            status = clcd_pkg::STATUS_TOO_LONG;
          end else if (ready_op) begin
            string_length_next = load_count_next;
            write_index_next   = 5'd0;
            request_busy_next  = 1'b1;
            request_type_next  = clcd_pkg::REQ_WRITE;
            accepted           = 1'b1;
          end
          load_count_next = 5'd0;
        end
      end
      default: ;
    endcase
  end

  // Response word, built from the updated state.
  always_comb begin
    res.status      = status;
    res.accepted    = accepted;
    res.busy_res    = request_busy_next;
    res.operational = (mode_next == clcd_pkg::MODE_OPER);
    res.done_res    = done;
    res.lcd_rs      = pin_rs_next;
    res.lcd_en      = en_level_next;
    res.lcd_data    = pin_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= clcd_pkg::MODE_OFF;
      init_step     <= clcd_pkg::STEP_POWER;
      request_type  <= clcd_pkg::REQ_WRITE;
      elapsed_ms    <= 16'd0;
      en_level      <= 1'b0;
      request_busy  <= 1'b0;
      string_length <= 5'd0;
      load_count    <= 5'd0;
      write_index   <= 5'd0;
      cursor_row    <= 1'b0;
      cursor_column <= 5'd1;
      pin_rs        <= 1'b0;
      pin_data      <= 8'd0;
    end else if (fire) begin
      mode          <= mode_next;
      init_step     <= init_step_next;
      request_type  <= request_type_next;
      elapsed_ms    <= elapsed_ms_next;
      en_level      <= en_level_next;
      request_busy  <= request_busy_next;
      string_length <= string_length_next;
      load_count    <= load_count_next;
      write_index   <= write_index_next;
      cursor_row    <= cursor_row_next;
      cursor_column <= cursor_column_next;
      pin_rs        <= pin_rs_next;
      pin_data      <= pin_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) string_store[load_count[clcd_pkg::StoreAw-1:0]] <= item.char_code;
  end

endmodule

FILE: rtl/char_lcd_async_controller_unit.sv
// Top level of the character LCD controller: command and response registers
// around clcd_core, plus the clcd_cfg_regs register file. Depends on clcd_pkg.

// This block runs an HD44780-style 8-bit character LCD. Each command word is
// a tick, an init, a clear, a set-cursor or one character of a string; a tick
// adds tick_ms to a saturating millisecond counter and advances either the
// timed power-up sequence or the pending request, toggling the enable pin
// on each tick that drives a transfer. For every command word exactly one
// response word comes back, carrying the status, the accepted/busy/
// operational/done flags and the pin levels after that word. The block takes
// one command word per clock cycle when the response side keeps up; a word
// is held in the command register, and its state update and response are
// computed combinationally by clcd_core and land in the response register
// once that register is free. The response register lets the next command
// enter while a finished response waits to be taken. Requests that arrive
// while another is in progress are answered with accepted low, and clear,
// set cursor or write requests are not taken before init completes.
// Configuration writes are always accepted (cfg_ready is tied high) and are
// meant to happen only while no command word is in flight.
module char_lcd_async_controller_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  clcd_pkg::cmd_word_t cmd_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output clcd_pkg::rsp_word_t rsp_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  clcd_pkg::cfg_regs_t cfg;
  clcd_pkg::cmd_word_t item;
  clcd_pkg::rsp_word_t core_res;
  logic                item_valid;
  logic                rsp_free;
  logic                advance;

  // The response register can take a new word when it is empty or being read.
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign advance   = item_valid && rsp_free;
  assign cmd_stall = item_valid && !rsp_free;

  clcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  clcd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Command register: refills whenever its word moves on or it is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!cmd_stall) begin
      item_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) item <= cmd_word;
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp_word <= core_res;
  end

endmodule

FILE: verif/clcd_rsp_checker.sv
// Response checker for the character LCD controller: watches the command,
// response and configuration channels, predicts every response word and
// compares it field by field. Depends on clcd_pkg.
module clcd_rsp_checker
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  logic        cmd_stall,
  input  cmd_word_t   cmd_word,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_word_t   rsp_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic [7:0]  lcd_tick_ms;
  logic [15:0] lcd_power_wait;
  logic [15:0] lcd_func_wait;
  logic [15:0] lcd_disp_wait;
  logic [15:0] lcd_entry_wait;

  // Shadow copy of the controller state.
  mode_t       lcd_mode;
  step_t       lcd_step;
  logic [15:0] lcd_elapsed;
  logic        lcd_busy;
  req_t        lcd_req;
  logic [7:0]  lcd_store [MaxChars];
  logic [4:0]  lcd_str_len;
  logic [4:0]  lcd_load_cnt;
  logic [4:0]  lcd_wr_idx;
  logic        lcd_cur_row;
  logic [4:0]  lcd_cur_col;
  logic        lcd_rs;
  logic        lcd_en;
  logic [7:0]  lcd_data;

  rsp_word_t   expected_rsp_words [$];
  int unsigned mismatches = 0;
  int unsigned rsp_seen = 0;

  assign fail_count = mismatches;

  // One enable phase: a rising strobe latches a new byte, a falling one keeps it.
  function automatic void drive_strobe(logic rs, logic [7:0] value);
    if (!lcd_en) begin
      lcd_data = value;
      lcd_en   = 1'b1;
    end else begin
      lcd_en = 1'b0;
    end
    lcd_rs = rs;
  endfunction

  // A timed init command finishes on a falling strobe once its wait has passed.
  function automatic bit send_timed(logic [7:0] cmd, logic [15:0] wait_ms);
    drive_strobe(1'b0, cmd);
    if (!lcd_en && lcd_elapsed > wait_ms) begin
      lcd_elapsed = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_word_t predict_rsp(cmd_word_t w);
    rsp_word_t   r;
    logic [16:0] sum;
    logic [7:0]  addr;
    logic        ready_op;
    r        = '0;
    ready_op = !lcd_busy && (lcd_mode == MODE_OPER);
    case (w.kind)
      KIND_TICK: begin
        sum         = {1'b0, lcd_elapsed} + {9'd0, lcd_tick_ms};
        lcd_elapsed = sum[16] ? ELAPSED_MAX : sum[15:0];
        if (lcd_mode == MODE_INIT) begin
          case (lcd_step)
            STEP_POWER: if (lcd_elapsed > lcd_power_wait) begin
              lcd_step    = STEP_FUNC;
              lcd_elapsed = '0;
            end
            STEP_FUNC:  if (send_timed(CMD_FUNC_SET, lcd_func_wait)) lcd_step = STEP_DISP;
            STEP_DISP:  if (send_timed(CMD_DISPLAY_ON, lcd_disp_wait)) lcd_step = STEP_CLEAR;
            STEP_CLEAR: if (send_timed(CMD_CLEAR, lcd_disp_wait)) lcd_step = STEP_ENTRY;
            STEP_ENTRY: if (send_timed(CMD_ENTRY, lcd_entry_wait)) lcd_step = STEP_END;
            STEP_END: begin
              lcd_mode   = MODE_OPER;
              lcd_busy   = 1'b0;
              r.done_res = 1'b1;
            end
            default: ;
          endcase
        end else if (lcd_mode == MODE_OPER && lcd_busy) begin
          if (lcd_req == REQ_WRITE) begin
            if (lcd_wr_idx < lcd_str_len && lcd_wr_idx < MaxChars) begin
              drive_strobe(1'b1, lcd_store[lcd_wr_idx[StoreAw-1:0]]);
              if (!lcd_en) lcd_wr_idx++;
            end else begin
              lcd_wr_idx = '0;
              lcd_busy   = 1'b0;
              r.done_res = 1'b1;
            end
          end else begin
            if (lcd_req == REQ_CLEAR) begin
              drive_strobe(1'b0, CMD_CLEAR);
            end else begin
              addr = (lcd_cur_row ? LINE2_BASE : 8'h00) + {3'd0, lcd_cur_col} - 8'd1;
              drive_strobe(1'b0, CMD_DDRAM + addr);
            end
            if (!lcd_en) begin
              lcd_busy   = 1'b0;
              r.done_res = 1'b1;
            end
          end
        end
      end
      KIND_INIT: begin
        if (!lcd_busy) begin
          lcd_mode   = MODE_INIT;
          lcd_step   = STEP_POWER;
          lcd_busy   = 1'b1;
          r.accepted = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (ready_op) begin
          lcd_busy   = 1'b1;
          lcd_req    = REQ_CLEAR;
          r.accepted = 1'b1;
        end
      end
      KIND_CURSOR: begin
        if (w.column == 5'd0 || w.column > MaxChars) begin
          r.status = STATUS_BAD_POS;
        end else if (ready_op) begin
          lcd_cur_row = w.row;
          lcd_cur_col = w.column;
          lcd_busy    = 1'b1;
          lcd_req     = REQ_CURSOR;
          r.accepted  = 1'b1;
        end
      end
      KIND_LOAD: begin
        // Characters that arrive while busy are counted but never stored.
        if (lcd_load_cnt < MaxChars && !lcd_busy) begin
          lcd_store[lcd_load_cnt[StoreAw-1:0]] = w.char_code;
        end
        if (lcd_load_cnt <= MaxChars) lcd_load_cnt++;
        if (w.last_char) begin
          if (lcd_load_cnt > MaxChars) begin
            r.status = STATUS_TOO_LONG;
          end else if (ready_op) begin
            lcd_str_len = lcd_load_cnt;
            lcd_wr_idx  = '0;
            lcd_busy    = 1'b1;
            lcd_req     = REQ_WRITE;
            r.accepted  = 1'b1;
          end
          lcd_load_cnt = '0;
        end
      end
      default: ;
    endcase
    r.busy_res    = lcd_busy;
    r.operational = (lcd_mode == MODE_OPER);
    r.lcd_rs      = lcd_rs;
    r.lcd_en      = lcd_en;
    r.lcd_data    = lcd_data;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("checker: response word %0d field %s expected %0h actual %0h",
                 rsp_seen, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      lcd_tick_ms    = 8'd2;
      lcd_power_wait = 16'd30;
      lcd_func_wait  = 16'd20;
      lcd_disp_wait  = 16'd20;
      lcd_entry_wait = 16'd10;
      lcd_mode       = MODE_OFF;
      lcd_step       = STEP_POWER;
      lcd_elapsed    = '0;
      lcd_busy       = 1'b0;
      lcd_req        = REQ_WRITE;
      lcd_str_len    = '0;
      lcd_load_cnt   = '0;
      lcd_wr_idx     = '0;
      lcd_cur_row    = 1'b0;
      lcd_cur_col    = 5'd1;
      lcd_rs         = 1'b0;
      lcd_en         = 1'b0;
      lcd_data       = '0;
      for (int i = 0; i < MaxChars; i++) lcd_store[i] = '0;
      expected_rsp_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICK_MS:       lcd_tick_ms    = cfg_data[7:0];
          REG_POWER_ON_WAIT: lcd_power_wait = cfg_data;
          REG_FUNC_SET_WAIT: lcd_func_wait  = cfg_data;
          REG_DISPLAY_WAIT:  lcd_disp_wait  = cfg_data;
          REG_ENTRY_WAIT:    lcd_entry_wait = cfg_data;
          default: ;
        endcase
      end
      // Responses are retired before the new command is queued, since a word
      // taken at this edge always belongs to an older command.
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (expected_rsp_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("checker: response word %0d arrived with none expected", rsp_seen);
          end
        end else begin
          want = expected_rsp_words.pop_front();
          check_field("status", want.status, rsp_word.status);
          check_field("accepted", want.accepted, rsp_word.accepted);
          check_field("busy_res", want.busy_res, rsp_word.busy_res);
          check_field("operational", want.operational, rsp_word.operational);
          check_field("done_res", want.done_res, rsp_word.done_res);
          check_field("lcd_rs", want.lcd_rs, rsp_word.lcd_rs);
          check_field("lcd_en", want.lcd_en, rsp_word.lcd_en);
          check_field("lcd_data", want.lcd_data, rsp_word.lcd_data);
        end
      end
      if (cmd_valid && !cmd_stall) expected_rsp_words.push_back(predict_rsp(cmd_word));
    end
    pending_count <= expected_rsp_words.size();
  end

endmodule

FILE: verif/char_lcd_async_controller_unit_tb.sv
// Top of the character LCD controller testbench: clock, reset, stimulus and
// verdict. Depends on clcd_pkg, clcd_rsp_checker and the controller RTL.
module char_lcd_async_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clcd_pkg::*;

  // Kind codes that the controller leaves without effect.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  cmd_word_t   cmd_word  = '0;
  logic        rsp_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = REG_TICK_MS;
  logic [15:0] cfg_data  = '0;
  logic        cmd_stall;
  logic        rsp_valid;
  logic        cfg_ready;
  rsp_word_t   rsp_word;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned words_sent      = 0;

  char_lcd_async_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees exactly the same pins as the controller and reports the
  // number of failures and of response words still outstanding.
  clcd_rsp_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd_word      (cmd_word),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp_word      (rsp_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The response side stalls at random; the rate changes from phase to phase.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // A command word with every field random apart from its kind, so that the
  // fields a kind does not use are exercised as well.
  function automatic cmd_word_t rand_word(logic [2:0] kind);
    cmd_word_t w;
    w.kind      = kind;
    w.char_code = 8'($urandom);
    w.last_char = 1'($urandom);
    w.row       = 1'($urandom);
    w.column    = 5'($urandom);
    return w;
  endfunction

  // Present one command word and hold it until the controller takes it. Idle
  // cycles go in front of the word, with valid low, so valid is never lowered
  // and raised in the same time step.
  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(rand_word(KIND_TICK));
  endtask

  // Stop sending and wait until every response word has been taken. The
  // pending count from the checker is registered, hence the first wait.
  task automatic drain_rsp();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Keeps valid high from one register to the next; apply_cfg lowers it.
  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Configuration is only changed while no command word is in flight.
  task automatic apply_cfg(input logic [7:0] tick_ms, input logic [15:0] power_wait,
                           input logic [15:0] func_wait, input logic [15:0] disp_wait,
                           input logic [15:0] entry_wait);
    drain_rsp();
    write_reg(REG_TICK_MS, {8'h00, tick_ms});
    write_reg(REG_POWER_ON_WAIT, power_wait);
    write_reg(REG_FUNC_SET_WAIT, func_wait);
    write_reg(REG_DISPLAY_WAIT, disp_wait);
    write_reg(REG_ENTRY_WAIT, entry_wait);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. Tick bursts give running requests time to finish, and
  // most strings are well formed so that real writes happen; some are too
  // long and some lose their last mark and run into the next string.
  task automatic run_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    cmd_word_t   w;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_ticks($urandom_range(1, 12));
      end else if (pick < 44) begin
        send_word(rand_word(KIND_INIT));
      end else if (pick < 52) begin
        send_word(rand_word(KIND_CLEAR));
      end else if (pick < 64) begin
        w = rand_word(KIND_CURSOR);
        if ($urandom_range(4) != 0) w.column = 5'($urandom_range(1, MaxChars));
        send_word(w);
      end else if (pick < 92) begin
        if ($urandom_range(9) == 0) len = $urandom_range(MaxChars + 1, MaxChars + 4);
        else len = $urandom_range(1, MaxChars);
        for (int i = 1; i <= len; i++) begin
          if ($urandom_range(4) == 0) send_ticks(1);
          w = rand_word(KIND_LOAD);
          w.last_char = (i == len) && ($urandom_range(9) != 0);
          send_word(w);
        end
      end else begin
        send_word(rand_word(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))));
      end
    end
  endtask

  initial begin
    cmd_word_t   w;
    int unsigned t;
    sender_idle_pct = 8;
    recv_stall_pct  = 71;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Ticks in the off mode only move the elapsed counter; these run with the
    // register values from reset.
    send_ticks(2);

    // Seventeen characters while nothing is busy: every store entry gets
    // written before any write request can read it, and the last mark on the
    // seventeenth character reports a string that is too long.
    for (int i = 0; i <= MaxChars; i++) begin
      w = rand_word(KIND_LOAD);
      if (i == 0) w.char_code = 8'h00;
      if (i == 1) w.char_code = 8'hFF;
      w.last_char = (i == MaxChars);
      send_word(w);
    end

    // Largest tick and zero waits: the whole init sequence takes ten ticks.
    apply_cfg(8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // A cursor request before init is not taken.
    w = rand_word(KIND_CURSOR);
    w.column = 5'd3;
    send_word(w);
    send_word(rand_word(KIND_INIT));
    send_ticks(10);

    // Column zero and a column past the end are rejected as bad positions.
    w = rand_word(KIND_CURSOR);
    w.column = 5'd0;
    send_word(w);
    w.column = 5'(MaxChars + 1);
    send_word(w);

    // Last column of the second line, then a clear, each with its two strobes.
    w = rand_word(KIND_CURSOR);
    w.row    = 1'b1;
    w.column = 5'(MaxChars);
    send_word(w);
    send_ticks(2);
    send_word(rand_word(KIND_CLEAR));
    send_ticks(2);

    // One-character write: two strobes and a finishing tick.
    w = rand_word(KIND_LOAD);
    w.last_char = 1'b1;
    send_word(w);
    send_ticks(3);

    // A spare kind, an init while operational, and a clear that is ignored
    // because the init is still busy.
    send_word(rand_word(KIND_SPARE_HI));
    send_word(rand_word(KIND_INIT));
    send_word(rand_word(KIND_CLEAR));

    // Saturation: with the largest power-on wait the elapsed counter climbs to
    // its ceiling and the power-on step never ends.
    apply_cfg(8'hFF, 16'hFFFF, 16'h0001, 16'h0001, 16'h0001);
    send_word(rand_word(KIND_INIT));
    send_ticks(270);

    // Phase A: random tick length with waits of a few ticks.
    t = $urandom_range(1, 255);
    apply_cfg(8'(t), 16'($urandom_range(0, 4 * t)), 16'($urandom_range(0, 4 * t)),
              16'($urandom_range(0, 4 * t)), 16'($urandom_range(0, 4 * t)));
    run_traffic(300);

    // Phase B: sender idles often, receiver rarely; one millisecond per tick.
    sender_idle_pct = 71;
    recv_stall_pct  = 8;
    apply_cfg(8'd1, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
              16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
    run_traffic(300);

    // Phase C: full rate on both sides with the longest tick.
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    apply_cfg(8'hFF, 16'($urandom_range(0, 1020)), 16'($urandom_range(0, 1020)),
              16'($urandom_range(0, 1020)), 16'($urandom_range(0, 1020)));
    run_traffic(300);

    // Let every response come back, then keep the clock running for anything stray.
    drain_rsp();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
